// ===== hw/rtl/aabb_overlap_pair_finder_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef AABB_OVERLAP_PAIR_FINDER_MACROS_SVH
`define AABB_OVERLAP_PAIR_FINDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AOPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AOPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aopf_pkg.sv =====
package aopf_pkg;

  localparam int OP_W      = 1;
  localparam int SLOT_W    = 5;
  localparam int SIZE_W    = 15;
  localparam int HIT_IDX_W = 5;

  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

// ===== hw/rtl/aabb_overlap_pair_finder.sv =====
// Box overlap finder. Stores up to TABLE_ENTRIES boxes in a single-port
// synchronous memory; a write request (op 0) updates one in-range slot and returns a
// single acknowledge (hit 0, last 1) in the following cycle. A query request (op 1)
// walks the table through the memory read port, one slot per cycle while
// no result stall holds it, and returns the index of every valid
// overlapping slot in ascending order, last set on the final one, or one
// miss item (hit 0, last 1) if nothing overlaps. A query keeps the block
// busy through its scan and flush states, and longer while the result side
// stalls. Valid marks clear at reset; no other initialization is needed.
module aabb_overlap_pair_finder #(
  parameter int TABLE_ENTRIES = 32,
  parameter int COORD_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [aopf_pkg::OP_W-1:0]         in_op,
  input  logic [aopf_pkg::SLOT_W-1:0]       in_entry_index,
  input  logic signed [COORD_BITS-1:0]      in_box_x,
  input  logic signed [COORD_BITS-1:0]      in_box_y,
  input  logic [aopf_pkg::SIZE_W-1:0]       in_box_w,
  input  logic [aopf_pkg::SIZE_W-1:0]       in_box_h,
  input  logic                              in_box_valid,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [aopf_pkg::HIT_IDX_W-1:0]    out_hit_index,
  output logic                              out_last
);

  import aopf_pkg::*;

`include "aabb_overlap_pair_finder_macros.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W + 1) + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_W-1:0]     w;
    logic [SIZE_W-1:0]     h;
  } entry_t;

  // Box table and its registered read data
  entry_t mem_r [TABLE_ENTRIES];
  entry_t mem_q_r;

  logic                     mem_we;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_waddr;
  logic [IDX_W-1:0]         mem_raddr;
  entry_t                   mem_wdata;

  state_t                   state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  entry_t                   q_r, q_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r, out_hit_nxt;
  logic [HIT_IDX_W-1:0]     out_hit_index_r, out_hit_index_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_free;
  logic                     in_fire;
  logic                     slot_in_range;
  logic                     overlap;
  logic                     hit_now;
  logic                     stall;

  logic signed [SUM_W-1:0]  qx_e, qy_e, sx_e, sy_e;
  logic signed [SUM_W-1:0]  qw_e, qh_e, sw_e, sh_e;

  // Sums are one bit wider than either operand, so nothing wraps.
  always_comb begin
    qx_e = SUM_W'(signed'(q_r.x));
    qy_e = SUM_W'(signed'(q_r.y));
    sx_e = SUM_W'(signed'(mem_q_r.x));
    sy_e = SUM_W'(signed'(mem_q_r.y));
    qw_e = signed'(SUM_W'(q_r.w));
    qh_e = signed'(SUM_W'(q_r.h));
    sw_e = signed'(SUM_W'(mem_q_r.w));
    sh_e = signed'(SUM_W'(mem_q_r.h));
    overlap = (qx_e + qw_e > sx_e) && (sx_e + sw_e > qx_e) &&
              (qy_e + qh_e > sy_e) && (sy_e + sh_e > qy_e);
  end

  assign out_free      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign slot_in_range = 32'(in_entry_index) < TABLE_ENTRIES;
  assign hit_now       = rd_pend_r && entry_valid_r[rd_idx_r] && overlap;
  // A second hit cannot move the pending one out while the output is full.
  assign stall         = hit_now && pend_vld_r && !out_free;

  assign mem_waddr = IDX_W'(in_entry_index);
  assign mem_raddr = cnt_r[IDX_W-1:0];
  assign mem_wdata = '{x: in_box_x, y: in_box_y, w: in_box_w, h: in_box_h};

  always_comb begin
    state_nxt         = state_r;
    entry_valid_nxt   = entry_valid_r;
    cnt_nxt           = cnt_r;
    rd_pend_nxt       = rd_pend_r;
    rd_idx_nxt        = rd_idx_r;
    pend_vld_nxt      = pend_vld_r;
    pend_idx_nxt      = pend_idx_r;
    q_nxt             = q_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_hit_nxt       = out_hit_r;
    out_hit_index_nxt = out_hit_index_r;
    out_last_nxt      = out_last_r;
    in_ready          = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          if (in_op == OP_QUERY) begin
            q_nxt     = mem_wdata;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            if (slot_in_range) begin
              mem_we                     = 1'b1;
              entry_valid_nxt[mem_waddr] = in_box_valid;
            end
            out_valid_nxt     = 1'b1;
            out_hit_nxt       = 1'b0;
            out_hit_index_nxt = '0;
            out_last_nxt      = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          // Hold one hit back until the next is found, so last can be set.
          if (hit_now) begin
            if (pend_vld_r) begin
              out_valid_nxt     = 1'b1;
              out_hit_nxt       = 1'b1;
              out_hit_index_nxt = HIT_IDX_W'(pend_idx_r);
              out_last_nxt      = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = rd_idx_r;
          end
          if (cnt_r < CNT_END) begin
            mem_re      = 1'b1;
            rd_pend_nxt = 1'b1;
            rd_idx_nxt  = mem_raddr;
            cnt_nxt     = cnt_r + CNT_W'(1);
          end else begin
            rd_pend_nxt = 1'b0;
            if (!rd_pend_r) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_hit_nxt       = pend_vld_r;
          out_hit_index_nxt = pend_vld_r ? HIT_IDX_W'(pend_idx_r) : '0;
          out_last_nxt      = 1'b1;
          pend_vld_nxt      = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_valid_r <= '0;
      cnt_r         <= '0;
      rd_pend_r     <= 1'b0;
      pend_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_valid_r <= entry_valid_nxt;
      cnt_r         <= cnt_nxt;
      rd_pend_r     <= rd_pend_nxt;
      pend_vld_r    <= pend_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r        <= rd_idx_nxt;
    pend_idx_r      <= pend_idx_nxt;
    q_r             <= q_nxt;
    out_hit_r       <= out_hit_nxt;
    out_hit_index_r <= out_hit_index_nxt;
    out_last_r      <= out_last_nxt;
  end

  // Writes happen only when idle and reads only while scanning, so the
  // same entry is never read and written in one cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem_r[mem_raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_index = out_hit_index_r;
  assign out_last      = out_last_r;

  `AOPF_ASSERT_NOW(a_idle_drained, state_r == ST_IDLE, !rd_pend_r && !pend_vld_r, "idle with scan work left")
  `AOPF_ASSERT_NOW(a_pend_valid_entry, pend_vld_r, entry_valid_r[pend_idx_r], "held hit names an invalid entry")
  `AOPF_ASSERT_NOW(a_miss_is_last, out_valid_r && !out_hit_r, out_last_r, "miss or acknowledge without last")
  `AOPF_ASSERT_NEXT(a_query_starts_scan, in_fire && in_op == OP_QUERY, state_r == ST_SCAN && cnt_r == '0, "query did not start a scan")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aopf_pkg::*;

  localparam int TABLE_ENTRIES = 32;
  localparam int COORD_BITS = 16;
  localparam int RANDOM_ITEMS = 320;
  localparam int CALM_TAIL = 40;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] slot;
    coord_t x;
    coord_t y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic keep;
  } box_req_t;

  typedef struct {
    logic hit;
    logic [HIT_IDX_W-1:0] idx;
    logic last;
  } pair_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = OP_WRITE;
  logic [SLOT_W-1:0] in_entry_index = '0;
  coord_t in_box_x = '0;
  coord_t in_box_y = '0;
  logic [SIZE_W-1:0] in_box_w = '0;
  logic [SIZE_W-1:0] in_box_h = '0;
  logic in_box_valid = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [HIT_IDX_W-1:0] out_hit_index;
  logic out_last;

  // shadow copy of the box store
  coord_t slot_x[TABLE_ENTRIES];
  coord_t slot_y[TABLE_ENTRIES];
  logic [SIZE_W-1:0] slot_w[TABLE_ENTRIES];
  logic [SIZE_W-1:0] slot_h[TABLE_ENTRIES];
  bit slot_live[TABLE_ENTRIES];

  box_req_t req_queue[$];
  pair_rsp_t pending_pairs[$];
  box_req_t sent_req;

  int mismatch_count = 0;
  int write_count = 0;
  int query_count = 0;
  int hit_count = 0;
  int miss_count = 0;
  int deepest_query = 0;
  int send_gap = 0;
  int send_idle_pct = 10;
  int recv_gap = 0;
  int recv_idle_pct = 10;
  int quiet_cycles = 0;

  aabb_overlap_pair_finder #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_entry_index(in_entry_index),
    .in_box_x(in_box_x),
    .in_box_y(in_box_y),
    .in_box_w(in_box_w),
    .in_box_h(in_box_h),
    .in_box_valid(in_box_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hit(out_hit),
    .out_hit_index(out_hit_index),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  function automatic bit spans_cross(coord_t a_lo, logic [SIZE_W-1:0] a_len,
                                     coord_t b_lo, logic [SIZE_W-1:0] b_len);
    int a0;
    int b0;
    a0 = a_lo;
    b0 = b_lo;
    return (a0 + int'(a_len) > b0) && (b0 + int'(b_len) > a0);
  endfunction

  task automatic predict_pairs(input box_req_t r);
    pair_rsp_t rsp;
    int found;
    found = 0;
    if (r.op == OP_WRITE) begin
      write_count++;
      if (int'(r.slot) < TABLE_ENTRIES) begin
        slot_x[r.slot] = r.x;
        slot_y[r.slot] = r.y;
        slot_w[r.slot] = r.w;
        slot_h[r.slot] = r.h;
        slot_live[r.slot] = r.keep;
      end
      rsp = '{hit: 1'b0, idx: '0, last: 1'b1};
      pending_pairs.push_back(rsp);
      return;
    end
    query_count++;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_live[i] && spans_cross(r.x, r.w, slot_x[i], slot_w[i]) &&
          spans_cross(r.y, r.h, slot_y[i], slot_h[i])) begin
        rsp = '{hit: 1'b1, idx: HIT_IDX_W'(i), last: 1'b0};
        pending_pairs.push_back(rsp);
        found++;
      end
    end
    if (found == 0) begin
      rsp = '{hit: 1'b0, idx: '0, last: 1'b1};
      pending_pairs.push_back(rsp);
      miss_count++;
    end else begin
      pending_pairs[pending_pairs.size() - 1].last = 1'b1;
      if (found > deepest_query) deepest_query = found;
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic add_write(input int slot, input int x, input int y, input int w,
                           input int h, input bit keep);
    box_req_t r;
    r.op = OP_WRITE;
    r.slot = SLOT_W'(slot);
    r.x = COORD_BITS'(x);
    r.y = COORD_BITS'(y);
    r.w = SIZE_W'(w);
    r.h = SIZE_W'(h);
    r.keep = keep;
    req_queue.push_back(r);
  endtask

  task automatic add_query(input int x, input int y, input int w, input int h);
    box_req_t r;
    r.op = OP_QUERY;
    r.slot = SLOT_W'($urandom);
    r.x = COORD_BITS'(x);
    r.y = COORD_BITS'(y);
    r.w = SIZE_W'(w);
    r.h = SIZE_W'(h);
    r.keep = 1'($urandom);
    req_queue.push_back(r);
  endtask

  function automatic int pick_size(int spread);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 8) return int'(SIZE_MAX);
    return $urandom_range(1, spread);
  endfunction

  // stimulus: directed corners, then clustered scenes with some noise
  initial begin
    box_req_t noise;
    int made;
    int base_x;
    int base_y;
    int spread;
    int n_wr;
    int n_qry;
    bit fill_all;
    int fill_slot;

    for (int i = 0; i < TABLE_ENTRIES; i++) slot_live[i] = 1'b0;

    add_query(0, 0, 10, 10);
    add_write(0, 0, 0, 10, 10, 1'b1);
    add_query(0, 0, 10, 10);
    add_query(10, 0, 5, 5);
    add_query(-5, 0, 5, 10);
    add_query(0, 10, 10, 5);
    add_query(5, 5, 0, 10);
    add_query(5, 5, 10, 0);
    add_write(31, -32768, -32768, 32767, 32767, 1'b1);
    add_write(17, 32767, 32767, 32767, 32767, 1'b1);
    add_query(-32768, -32768, 32767, 32767);
    add_query(32767, 32767, 1, 1);
    add_query(-1, -1, 32767, 32767);
    add_write(5, 2, 2, 3, 3, 1'b1);
    add_write(9, 3, 3, 0, 4, 1'b1);
    add_query(0, 0, 10, 10);
    add_write(0, 0, 0, 10, 10, 1'b0);
    add_query(0, 0, 10, 10);
    add_write(0, 100, 100, 20, 20, 1'b0);
    add_query(100, 100, 20, 20);
    add_write(0, 100, 100, 20, 20, 1'b1);
    add_query(105, 95, 1, 10);
    add_query(32767, -32768, 32767, 32767);
    add_write(31, 0, 0, 32767, 32767, 1'b0);
    add_query(-32768, -32768, 32767, 32767);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      base_x = $urandom_range(0, 65535);
      base_y = $urandom_range(0, 65535);
      case ($urandom_range(0, 3))
        0: spread = 8;
        1: spread = 40;
        2: spread = 300;
        default: spread = 5000;
      endcase
      fill_all = ($urandom_range(0, 9) == 0);
      n_wr = fill_all ? TABLE_ENTRIES : $urandom_range(2, 12);
      n_qry = $urandom_range(1, 6);
      fill_slot = 0;
      while (n_wr + n_qry > 0) begin
        if ($urandom_range(0, 99) < 8) begin
          noise.op = OP_W'($urandom);
          noise.slot = SLOT_W'($urandom);
          noise.x = COORD_BITS'($urandom);
          noise.y = COORD_BITS'($urandom);
          noise.w = SIZE_W'($urandom);
          noise.h = SIZE_W'($urandom);
          noise.keep = 1'($urandom);
          req_queue.push_back(noise);
        end else if (n_wr > 0 && (fill_all || n_qry == 0 || $urandom_range(0, 2) != 0)) begin
          add_write(fill_all ? fill_slot : $urandom_range(0, TABLE_ENTRIES - 1),
                    base_x + $urandom_range(0, spread), base_y + $urandom_range(0, spread),
                    pick_size(spread), pick_size(spread), $urandom_range(0, 9) != 0);
          fill_slot++;
          n_wr--;
        end else begin
          // wide queries sweep up most of the cluster
          if ($urandom_range(0, 3) == 0)
            add_query(base_x - 1, base_y - 1, 2 * spread + 2, 2 * spread + 2);
          else
            add_query(base_x + $urandom_range(0, spread), base_y + $urandom_range(0, spread),
                      pick_size(spread), pick_size(spread));
          n_qry--;
        end
        made++;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_pairs(sent_req);
      if (!in_valid || in_ready) begin
        if ($urandom_range(0, 49) == 0) send_idle_pct = 15 * $urandom_range(0, 2);
        if (req_queue.size() < CALM_TAIL) send_gap = 0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_queue.size() >= CALM_TAIL &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          sent_req = req_queue.pop_front();
          in_valid <= 1'b1;
          in_op <= sent_req.op;
          in_entry_index <= sent_req.slot;
          in_box_x <= sent_req.x;
          in_box_y <= sent_req.y;
          in_box_w <= sent_req.w;
          in_box_h <= sent_req.h;
          in_box_valid <= sent_req.keep;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if ($urandom_range(0, 49) == 0) recv_idle_pct = 15 * $urandom_range(0, 2);
    if (req_queue.size() < CALM_TAIL) recv_gap = 0;
    if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (rst_n && req_queue.size() >= CALM_TAIL &&
                 $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    pair_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        flag_mismatch($sformatf("unexpected result hit=%0b index=%0d last=%0b",
                                out_hit, out_hit_index, out_last));
      end else begin
        want = pending_pairs.pop_front();
        if (out_hit) hit_count++;
        if (out_hit !== want.hit)
          flag_mismatch($sformatf("hit got %0b want %0b", out_hit, want.hit));
        if (out_hit_index !== want.idx)
          flag_mismatch($sformatf("hit_index got %0d want %0d", out_hit_index, want.idx));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
      end
    end
  end

  // hang detector: nothing moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               quiet_cycles, pending_pairs.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (req_queue.size() > 0 || in_valid || pending_pairs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d box writes and %0d queries (%0d empty)", write_count,
             query_count, miss_count);
    $display("%0d overlap hits reported, up to %0d from one query", hit_count,
             deepest_query);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
